// ----- rtl/nnis_pkg.sv -----
// Shared constants, register indexes and controller/datapath interface types for the scaler.
package nnis_pkg;

   localparam int STORE_PIXELS_DEF = 65536;
   localparam int MAX_DIM_DEF      = 2048;

   localparam int REG_W       = 12;
   localparam int REG_COUNT   = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int CHAN_W      = 8;
   localparam int COLOR_W     = 3 * CHAN_W;
   localparam int ARGB_W      = 4 * CHAN_W;

   localparam logic [CSR_INDEX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_TARGET_WIDTH  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_TARGET_HEIGHT = 2'd3;

   localparam logic [REG_W-1:0]  REG_RESET    = 12'd256;
   localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_FETCH = 1'b1;

   typedef struct packed {
      logic load_we;
      logic start;
      logic mul_en;
      logic adr_en;
      logic rd_en;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic div_done;
   } sts_type;

endpackage

// ----- rtl/nnis_divider.sv -----
// Restoring divider that resolves one quotient bit per cycle.
module nnis_divider
   import nnis_pkg::*;
#(
   parameter int NW = 23,
   parameter int DW = 12
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] numer,
   input  logic [DW-1:0] denom,
   output logic [NW-1:0] quot,
   output logic          done
);

   localparam int CNT_W = $clog2(NW + 1);

   logic [NW-1:0]    work_ff, work_in;
   logic [DW-1:0]    rem_ff, rem_in;
   logic [DW-1:0]    denom_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DW:0]      trial;
   logic             fits;

   // Shift the next numerator bit into the partial remainder and try the divisor.
   assign trial = {rem_ff, work_ff[NW-1]};
   assign fits  = trial >= {1'b0, denom_ff};

   always_comb begin
      work_in  = work_ff;
      rem_in   = rem_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = done_ff;
      if (start) begin
         work_in  = numer;
         rem_in   = '0;
         count_in = CNT_W'(NW);
         busy_in  = 1'b1;
         done_in  = 1'b0;
      end else if (busy_ff) begin
         work_in  = {work_ff[NW-2:0], fits};
         rem_in   = fits ? DW'(trial - {1'b0, denom_ff}) : trial[DW-1:0];
         count_in = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rem_ff  <= rem_in;
      if (start) begin
         denom_ff <= denom;
      end
   end

   assign quot = work_ff;
   assign done = done_ff;

endmodule

// ----- rtl/nnis_datapath.sv -----
// Scaler datapath: registers, raster counters, coordinate dividers, pixel store and result word.
module nnis_datapath
   import nnis_pkg::*;
#(
   parameter int STORE_PIXELS  = STORE_PIXELS_DEF,
   parameter int MAX_DIMENSION = MAX_DIM_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [REG_W-1:0]       csr_data,
   input  logic [COLOR_W-1:0]     load_color,
   input  cmd_type                cmd,
   output sts_type                sts,
   output logic [ARGB_W-1:0]      rsp_data,
   output logic                   rsp_last
);

   localparam int CW   = $clog2(MAX_DIMENSION);
   localparam int DW   = $clog2(MAX_DIMENSION + 1);
   localparam int NW   = CW + DW;
   localparam int AW   = NW + 1;
   localparam int SAW  = $clog2(STORE_PIXELS);
   localparam int LPW  = $clog2(STORE_PIXELS + 1);
   localparam int CMPW = (AW > LPW) ? AW : LPW;
   localparam int RCW  = (REG_W > DW) ? REG_W : DW;

   logic [REG_W-1:0] cfg_ff [REG_COUNT];
   logic [DW-1:0]    dim_eff [REG_COUNT];
   logic [DW-1:0]    sw_eff, sh_eff, tw_eff, th_eff;

   logic [LPW-1:0]   load_pos_ff;
   logic [CW-1:0]    col_ff, row_ff;
   logic [CW:0]      col_inc, row_inc;
   logic             col_end, row_end, room;

   logic [DW-1:0]    sw_ff, sh_ff;
   logic             col_ge_ff, row_ge_ff, last_ff;
   logic [NW-1:0]    numer_x, numer_y, quot_x, quot_y;
   logic             done_x, done_y;
   logic [CW-1:0]    sx, sy, sx_ff;
   logic [NW-1:0]    prod_ff;
   logic [AW-1:0]    addr_sum, addr_ff;
   logic             in_range_ff, in_range2_ff;

   logic [COLOR_W-1:0] store_mem [STORE_PIXELS];
   logic [COLOR_W-1:0] rd_data_ff;
   logic [ARGB_W-1:0]  rsp_data_ff;
   logic               rsp_last_ff;

   // Register value 0 is used as 1, anything above the maximum as the maximum.
   always_comb begin
      for (int i = 0; i < REG_COUNT; i++) begin
         if (cfg_ff[i] == '0) begin
            dim_eff[i] = DW'(1);
         end else if (RCW'(cfg_ff[i]) > RCW'(MAX_DIMENSION)) begin
            dim_eff[i] = DW'(MAX_DIMENSION);
         end else begin
            dim_eff[i] = DW'(cfg_ff[i]);
         end
      end
   end

   assign sw_eff = dim_eff[REG_SOURCE_WIDTH];
   assign sh_eff = dim_eff[REG_SOURCE_HEIGHT];
   assign tw_eff = dim_eff[REG_TARGET_WIDTH];
   assign th_eff = dim_eff[REG_TARGET_HEIGHT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) begin
            cfg_ff[i] <= REG_RESET;
         end
      end else if (csr_we) begin
         cfg_ff[csr_index] <= csr_data;
      end
   end

   // Raster position of the next destination pixel.
   assign col_inc = {1'b0, col_ff} + (CW + 1)'(1);
   assign row_inc = {1'b0, row_ff} + (CW + 1)'(1);
   assign col_end = col_inc >= (CW + 1)'(tw_eff);
   assign row_end = row_inc >= (CW + 1)'(th_eff);
   assign room    = load_pos_ff < LPW'(STORE_PIXELS);

   always_ff @(posedge clock) begin
      if (reset) begin
         load_pos_ff <= '0;
         col_ff      <= '0;
         row_ff      <= '0;
      end else if (cmd.load_we) begin
         if (room) begin
            load_pos_ff <= load_pos_ff + LPW'(1);
         end
      end else if (cmd.start) begin
         if (col_end) begin
            col_ff <= '0;
            if (row_end) begin
               row_ff      <= '0;
               load_pos_ff <= '0;
            end else begin
               row_ff <= row_inc[CW-1:0];
            end
         end else begin
            col_ff <= col_inc[CW-1:0];
         end
      end
   end

   // Source coordinate is pos * src / dst; a position at or past dst clamps to src - 1.
   assign numer_x = NW'(col_ff) * NW'(sw_eff);
   assign numer_y = NW'(row_ff) * NW'(sh_eff);

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         sw_ff     <= sw_eff;
         sh_ff     <= sh_eff;
         col_ge_ff <= {1'b0, col_ff} >= (CW + 1)'(tw_eff);
         row_ge_ff <= {1'b0, row_ff} >= (CW + 1)'(th_eff);
         last_ff   <= col_end & row_end;
      end
   end

   nnis_divider #(.NW(NW), .DW(DW)) u_div_x (
      .clock (clock),
      .reset (reset),
      .start (cmd.start),
      .numer (numer_x),
      .denom (tw_eff),
      .quot  (quot_x),
      .done  (done_x)
   );

   nnis_divider #(.NW(NW), .DW(DW)) u_div_y (
      .clock (clock),
      .reset (reset),
      .start (cmd.start),
      .numer (numer_y),
      .denom (th_eff),
      .quot  (quot_y),
      .done  (done_y)
   );

   assign sts.div_done = done_x & done_y;

   assign sx = col_ge_ff ? CW'(sw_ff - DW'(1)) : quot_x[CW-1:0];
   assign sy = row_ge_ff ? CW'(sh_ff - DW'(1)) : quot_y[CW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= NW'(sy) * NW'(sw_ff);
         sx_ff   <= sx;
      end
   end

   assign addr_sum = AW'(prod_ff) + AW'(sx_ff);

   always_ff @(posedge clock) begin
      if (cmd.adr_en) begin
         addr_ff     <= addr_sum;
         in_range_ff <= CMPW'(addr_sum) < CMPW'(STORE_PIXELS);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_we && room) begin
         store_mem[SAW'(load_pos_ff)] <= load_color;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff   <= store_mem[SAW'(addr_ff)];
         in_range2_ff <= in_range_ff;
      end
   end

   // Addresses outside the store read as black.
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff <= {ALPHA_OPAQUE, in_range2_ff ? rd_data_ff : COLOR_W'(0)};
         rsp_last_ff <= last_ff;
      end
   end

   assign rsp_data = rsp_data_ff;
   assign rsp_last = rsp_last_ff;

endmodule

// ----- rtl/nnis_controller.sv -----
// Scaler controller: sequences divide, multiply, address, store read and output of a fetch.
module nnis_controller
   import nnis_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   input  logic    req_tuser,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_DIV  = 6'b000010,
      ST_MUL  = 6'b000100,
      ST_ADR  = 6'b001000,
      ST_RD   = 6'b010000,
      ST_OUT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE) && !reset;
   assign accept     = req_tvalid & req_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser == FUNC_FETCH) begin
                  cmd.start = 1'b1;
                  state_in  = ST_DIV;
               end else begin
                  cmd.load_we = 1'b1;
               end
            end
         end
         ST_DIV: begin
            if (sts.div_done) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_ADR;
         end
         ST_ADR: begin
            cmd.adr_en = 1'b1;
            state_in   = ST_RD;
         end
         ST_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ----- rtl/nearest_neighbor_image_scaler_unit.sv -----
// Top level of the nearest-neighbor image scaler: controller, datapath and configuration port.
//
//   Channel  Direction  Handshake            Payload
//   req_     in         req_tvalid/tready    tuser = func, tdata = red, green, blue
//   rsp_     out        rsp_tvalid/tready    tdata = argb_pixel, tlast = frame_last
//   csr_     in         csr_valid/ready      csr_index = register, csr_data = value
//
// A load word is written straight into the pixel store. A fetch word passes
// through the accepting step, the divide in the two bit-serial coordinate
// dividers (NW, their numerator width, is log2 of MAX_DIMENSION plus the
// dimension width), then multiply, address, store read and output; the next
// word is taken only after the output step.
// Reset is synchronous and active high; it clears the counters, the registers
// (to 256) and the handshake state, but not the pixel store. Neither the
// request nor the register channel is ready while reset is held.
// The output register holds a finished word while the input side already
// takes the next word, so a stalled result costs cycles only when a second
// request is ready to deliver.
module nearest_neighbor_image_scaler_unit
   import nnis_pkg::*;
#(
   parameter int STORE_PIXELS  = STORE_PIXELS_DEF,
   parameter int MAX_DIMENSION = MAX_DIM_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // Request stream.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [COLOR_W-1:0]     req_tdata,   // [7:0] red, [15:8] green, [23:16] blue
   input  logic                   req_tuser,   // [0] func: 0 load pixel, 1 fetch pixel
   // Result stream.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [ARGB_W-1:0]      rsp_tdata,   // [31:0] argb_pixel
   output logic                   rsp_tlast,
   // Register write channel.
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [REG_W-1:0]       csr_data
);

   cmd_type cmd;
   sts_type sts;
   logic    csr_we;

   // Registers are writable whenever reset is low; the user writes them only while idle.
   assign csr_ready = !reset;
   assign csr_we    = csr_valid & csr_ready;

   nnis_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // The tdata byte order is red low, blue high; the store keeps red high, blue low.
   nnis_datapath #(
      .STORE_PIXELS  (STORE_PIXELS),
      .MAX_DIMENSION (MAX_DIMENSION)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .load_color ({req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]}),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_data   (rsp_tdata),
      .rsp_last   (rsp_tlast)
   );

endmodule

// ----- rtl/nnis_checker.sv -----
// Port-level checks for the scaler, bound to its top level.
module nnis_checker
   import nnis_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_tvalid,
   input logic              req_tready,
   input logic              req_tuser,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [ARGB_W-1:0] rsp_tdata,
   input logic              rsp_tlast
);

   // A stalled result word keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result word changed while stalled");

   // Every result pixel is opaque.
   a_alpha: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[ARGB_W-1:ARGB_W-CHAN_W] == ALPHA_OPAQUE)
      else $error("result pixel not opaque");

   // A load word never produces a result.
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == FUNC_LOAD && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result appeared after a load word");

   // A fetch word occupies the block for the following cycle at least.
   a_fetch_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == FUNC_FETCH |=> !req_tready)
      else $error("input ready right after a fetch word");

endmodule

bind nearest_neighbor_image_scaler_unit nnis_checker u_nnis_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

// ----- tb/testbench.sv -----
// Self-checking testbench for the nearest-neighbor image scaler with bursty traffic and a pixel scoreboard.
`timescale 1ns / 1ps

module testbench;
   import nnis_pkg::*;

   // A small store keeps the full-store fill short.
   localparam int STORE_DEPTH   = 1024;
   localparam int MAX_DIM       = MAX_DIM_DEF;
   // This covers a fetch at the default sizes with margin.
   localparam int SETTLE_CYCLES = 64;
   localparam int RANDOM_WORDS  = 40;
   localparam int HOLD_CYCLES   = 400;
   localparam int CYCLE_LIMIT   = 2000000;

   typedef struct packed {
      logic [ARGB_W-1:0] argb;
      logic              frame_last;
   } pixel_word_type;

   // Scoreboard: keeps its own copy of the pixel store, the load and output
   // counters and the geometry registers, and queues one expected pixel per
   // accepted fetch word.
   class pixel_scoreboard;
      bit [COLOR_W-1:0] store [STORE_DEPTH];
      bit [REG_W-1:0]   regs [REG_COUNT];
      int unsigned      load_pos;
      int unsigned      out_col;
      int unsigned      out_row;
      pixel_word_type   awaited[$];
      int               errors;

      function new();
         foreach (regs[i]) regs[i] = REG_RESET;
      endfunction

      // A register of zero acts as one, anything above the maximum as the maximum.
      function int unsigned dim(input int unsigned raw);
         if (raw == 0) return 1;
         if (raw > MAX_DIM) return MAX_DIM;
         return raw;
      endfunction

      // Destination position to source position, clamped to the last source index.
      function int unsigned src_coord(input int unsigned pos, input int unsigned src,
                                      input int unsigned dst);
         longint unsigned s;
         s = pos;
         s = s * src / dst;
         if (s >= src) s = src - 1;
         return s[31:0];
      endfunction

      function void note_config(input logic [CSR_INDEX_W-1:0] index,
                                input logic [REG_W-1:0] value);
         regs[index] = value;
      endfunction

      function void note_word(input logic func, input logic [COLOR_W-1:0] data);
         int unsigned      sw, sh, tw, th, sx, sy;
         longint unsigned  addr;
         bit [COLOR_W-1:0] color;
         pixel_word_type   px;
         if (func == FUNC_LOAD) begin
            // Loads past the end of the store are dropped.
            if (load_pos < STORE_DEPTH) begin
               store[load_pos] = {data[7:0], data[15:8], data[23:16]};
               load_pos++;
            end
         end else begin
            sw = dim(regs[REG_SOURCE_WIDTH]);
            sh = dim(regs[REG_SOURCE_HEIGHT]);
            tw = dim(regs[REG_TARGET_WIDTH]);
            th = dim(regs[REG_TARGET_HEIGHT]);
            sx = src_coord(out_col, sw, tw);
            sy = src_coord(out_row, sh, th);
            addr = sy;
            addr = addr * sw + sx;
            color = '0;
            if (addr < STORE_DEPTH) color = store[int'(addr)];
            px.argb = {ALPHA_OPAQUE, color};
            px.frame_last = 1'b0;
            if (out_col + 1 >= tw) begin
               out_col = 0;
               if (out_row + 1 >= th) begin
                  out_row = 0;
                  load_pos = 0;
                  px.frame_last = 1'b1;
               end else begin
                  out_row++;
               end
            end else begin
               out_col++;
            end
            awaited.push_back(px);
         end
      endfunction

      function void check_result(input logic [ARGB_W-1:0] argb, input logic last);
         pixel_word_type px;
         if (awaited.size() == 0) begin
            $display("%0t: result with nothing expected, argb_pixel %h frame_last %b",
                     $time, argb, last);
            errors++;
            return;
         end
         px = awaited.pop_front();
         if (argb !== px.argb) begin
            $display("%0t: argb_pixel mismatch, expected %h, actual %h", $time, px.argb, argb);
            errors++;
         end
         if (last !== px.frame_last) begin
            $display("%0t: frame_last mismatch, expected %b, actual %b",
                     $time, px.frame_last, last);
            errors++;
         end
      endfunction
   endclass

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [COLOR_W-1:0]     req_tdata  = '0;
   logic                   req_tuser  = FUNC_LOAD;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [ARGB_W-1:0]      rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [REG_W-1:0]       csr_data   = '0;

   pixel_scoreboard sb;
   // Words left in the sender's current burst; zero starts a gap first.
   int              burst_left       = 0;
   // Set by the stimulus to make the receiver hold off for a long stretch.
   bit              hold_off_request = 1'b0;
   int unsigned     cycle_count      = 0;

   always #5 clock = ~clock;

   nearest_neighbor_image_scaler_unit #(
      .STORE_PIXELS  (STORE_DEPTH),
      .MAX_DIMENSION (MAX_DIM)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Every handshake is observed here, on the values from before the edge.
   // Results are checked before a new fetch is noted, since a result can
   // never belong to a word accepted at the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tlast);
         if (req_tvalid && req_tready) sb.note_word(req_tuser, req_tdata);
         if (csr_valid && csr_ready)   sb.note_config(csr_index, csr_data);
      end
   end

   // Watchdog: a missing result or a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Receiver: switches between several stall patterns at random intervals,
   // and holds off completely for a long stretch on request so the output
   // register fills and the block has to stall its input.
   initial begin : result_sink
      int unsigned mode;
      int unsigned mode_left;
      int unsigned hold_left;
      int unsigned tick;
      mode_left = 0;
      hold_left = 0;
      tick      = 0;
      forever begin
         @(posedge clock);
         tick++;
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 3);
               mode_left = $urandom_range(50, 400);
            end
            mode_left--;
            case (mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= ($urandom_range(0, 1) == 1);
               2:       rsp_tready <= (tick % 4 == 0);
               default: rsp_tready <= (tick % 8 != 0);
            endcase
         end
      end
   end

   // Offers one word and returns at the edge where it is taken. The sender
   // runs in bursts; each burst is preceded by an idle gap of random length,
   // and some bursts are long enough to give stretches with no idling.
   task automatic send_word(input logic func, input logic [COLOR_W-1:0] data);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 16);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= data;
      burst_left--;
      do @(posedge clock); while (!req_tready);
   endtask

   // Stops sending, waits for every expected pixel, then lets the block
   // finish any load still in flight.
   task automatic settle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (sb.awaited.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index, input int unsigned value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value[REG_W-1:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // New source and target geometry, written only once the block is idle.
   task automatic reshape(input int unsigned sw, input int unsigned sh,
                          input int unsigned tw, input int unsigned th);
      settle();
      write_reg(REG_SOURCE_WIDTH, sw);
      write_reg(REG_SOURCE_HEIGHT, sh);
      write_reg(REG_TARGET_WIDTH, tw);
      write_reg(REG_TARGET_HEIGHT, th);
   endtask

   initial begin : stimulus
      int unsigned dims [4];
      int unsigned tw, th;
      int          frame_left;
      int          n_load;
      int          n_req;
      int          random_words;
      int          phase;
      random_words = 0;
      phase        = 0;
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Fill the whole store, then offer three more loads that must be
      // dropped. After this every entry has been written, so any later read
      // is legal.
      for (int i = 0; i < STORE_DEPTH + 3; i++) begin
         case (i)
            0:       send_word(FUNC_LOAD, '0);
            1:       send_word(FUNC_LOAD, '1);
            default: send_word(FUNC_LOAD, COLOR_W'($urandom));
         endcase
      end

      // Identity mapping at the reset registers reads entries 0 to 2; entry 0
      // shows that the loads past a full store did not wrap around.
      repeat (3) send_word(FUNC_FETCH, COLOR_W'($urandom));

      // Shrink the target under a column of 3: the row ends at once and the
      // source column clamps. All three pixels map past the store and read
      // as zero color; the third closes the frame.
      reshape(MAX_DIM, MAX_DIM, 2, 2);
      repeat (3) send_word(FUNC_FETCH, COLOR_W'($urandom));

      // Zero widths act as one and oversized heights as the maximum. The new
      // frame loads from the start of the store while pixels go out.
      reshape(0, 4095, 0, 4095);
      repeat (2) send_word(FUNC_LOAD, COLOR_W'($urandom));
      repeat (3) send_word(FUNC_FETCH, COLOR_W'($urandom));

      // Row 3 is already past a target height of 2, so this pixel is the last.
      reshape(0, 4095, 0, 2);
      send_word(FUNC_FETCH, COLOR_W'($urandom));

      // Random frames: mostly a load of the source image followed by fetches
      // to the end of the frame, with stray loads mixed in. Some phases are
      // loads and fetches in random order, and large or out-of-range sizes
      // turn up now and then, leaving the counters past the new target.
      // The second phase always has the receiver hold off.
      while (random_words < RANDOM_WORDS || phase < 2) begin
         phase++;
         foreach (dims[k]) begin
            case ($urandom_range(0, 19))
               0:       dims[k] = 0;
               1:       dims[k] = 4095;
               2:       dims[k] = MAX_DIM;
               3:       dims[k] = $urandom_range(1, 4095);
               4, 5:    dims[k] = $urandom_range(9, 40);
               default: dims[k] = $urandom_range(1, 8);
            endcase
         end
         reshape(dims[0], dims[1], dims[2], dims[3]);
         tw = sb.dim(dims[2]);
         th = sb.dim(dims[3]);
         // Fetches still needed to reach the last pixel from where the
         // counters stand now.
         frame_left = (sb.out_col + 1 >= tw) ? 1 : tw - sb.out_col;
         if (sb.out_row + 1 < th) frame_left += (th - sb.out_row - 1) * tw;

         if (phase % 5 != 2 && $urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(10, 40)) begin
               send_word(($urandom_range(0, 1) == 1) ? FUNC_FETCH : FUNC_LOAD,
                         COLOR_W'($urandom));
               random_words++;
            end
         end else begin
            n_load = sb.dim(dims[0]) * sb.dim(dims[1]);
            if (n_load > 96) n_load = $urandom_range(1, 96);
            n_req = (frame_left <= 96) ? frame_left : $urandom_range(1, 48);
            repeat (n_load) begin
               send_word(FUNC_LOAD, COLOR_W'($urandom));
               random_words++;
            end
            // Now and then the receiver goes quiet while fetches keep coming.
            if (phase % 5 == 2) begin
               hold_off_request = 1'b1;
               n_req += 16;
            end
            repeat (n_req) begin
               if ($urandom_range(0, 9) == 0) begin
                  send_word(FUNC_LOAD, COLOR_W'($urandom));
                  random_words++;
               end
               send_word(FUNC_FETCH, COLOR_W'($urandom));
               random_words++;
            end
         end
      end

      settle();
      if (sb.errors == 0 && sb.awaited.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ----- nearest_neighbor_image_scaler_unit.f -----
rtl/nnis_pkg.sv
rtl/nnis_divider.sv
rtl/nnis_datapath.sv
rtl/nnis_controller.sv
rtl/nearest_neighbor_image_scaler_unit.sv
rtl/nnis_checker.sv
tb/testbench.sv
